>>> rtl/xs128p_pkg.sv
// Package for the xorshift128+ generator with Lehmer seeding.
// Holds widths, arithmetic constants, controller states and the control structs.
// No dependencies.
package xs128p_pkg;

    localparam int WORD_W        = 64;
    localparam int SEED_W        = 32;
    localparam int PROD_W        = 48;
    localparam int FRACTION_BITS = 52;

    localparam logic [PROD_W-1:0] LEHMER_MUL = 48'd48271;
    localparam logic [SEED_W-1:0] LEHMER_MOD = 32'd2147483647;

    localparam int SHIFT_A = 23;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 26;

    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED
    } t_state;

    typedef struct packed {
        logic load_seed;
        logic mul;
        logic red;
        logic advance;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_ctrl_sts;

endpackage

>>> rtl/xs128p_ctrl.sv
// Controller for the xorshift128+ generator: request acceptance and the
// four-step Lehmer seeding sequence. Depends on xs128p_pkg.
module xs128p_ctrl
    import xs128p_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_cmd,
    output logic      o_in_ready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;
    logic       accept;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd == CMD_SEED) begin
                    n_state = ST_MUL;
                    n_step  = '0;
                end
            end
            ST_MUL: begin
                n_state = ST_RED;
            end
            ST_RED: begin
                if (r_step == 2'd3) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_MUL;
                    n_step  = r_step + 2'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready      = i_sts.out_free;
                o_cmd.load_seed = accept && i_cmd == CMD_SEED;
                o_cmd.advance   = accept && i_cmd == CMD_NEXT;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_RED: begin
                o_cmd.red = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/xs128p_dp.sv
// Datapath for the xorshift128+ generator: state words, Lehmer multiply and
// Mersenne reduction, shift-xor update and output register. Depends on xs128p_pkg.
module xs128p_dp
    import xs128p_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl_cmd                i_cmd,
    output t_ctrl_sts                o_sts,
    input  logic [SEED_W-1:0]        i_seed_value,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [FRACTION_BITS-1:0] o_random_fraction
);

    logic [WORD_W-1:0]        r_word_a, r_word_b;
    logic [SEED_W-1:0]        r_lehmer;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_out_valid;
    logic [FRACTION_BITS-1:0] r_out;

    logic [SEED_W-1:0] red_sum;
    logic [SEED_W-1:0] red_val;
    logic [WORD_W-1:0] x1, x2, x3;
    logic [WORD_W-1:0] out_sum;

    assign red_sum = {1'b0, r_prod[SEED_W-2:0]}
                   + {{(2*SEED_W-PROD_W-1){1'b0}}, r_prod[PROD_W-1:SEED_W-1]};
    assign red_val = (red_sum >= LEHMER_MOD) ? red_sum - LEHMER_MOD : red_sum;

    assign x1      = r_word_a ^ (r_word_a << SHIFT_A);
    assign x2      = x1 ^ (x1 >> SHIFT_B);
    assign x3      = x2 ^ r_word_b ^ (r_word_b >> SHIFT_C);
    assign out_sum = r_word_b + x3;

    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_random_fraction = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_a    <= '0;
            r_word_b    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.advance) begin
                r_word_a    <= r_word_b;
                r_word_b    <= x3;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.red) begin
                {r_word_b, r_word_a} <= {red_val, r_word_b, r_word_a[WORD_W-1:SEED_W]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.advance) begin
            r_out <= out_sum[FRACTION_BITS-1:0];
        end
        if (i_cmd.load_seed) begin
            r_lehmer <= i_seed_value;
        end else if (i_cmd.red) begin
            r_lehmer <= red_val;
        end
        if (i_cmd.mul) begin
            r_prod <= {{(PROD_W-SEED_W){1'b0}}, r_lehmer} * LEHMER_MUL;
        end
    end

endmodule

>>> rtl/xorshift128plus_rng_with_lehmer_seed.sv
// Top level of the xorshift128+ generator with Lehmer seeding.
// Joins xs128p_ctrl and xs128p_dp; depends on xs128p_pkg.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_cmd, i_seed_value
//   out      output     o_out_valid / i_out_ready  o_random_fraction
//
// A next request's result sits in the output register.
// A seed request runs through the accept, then four Lehmer steps, each
// a multiply state and a modular reduction state, and gives no result.
// Requests are taken only while the controller is idle and the output register is empty or being drained.
// Reset is synchronous, active low, and clears both state words to zero.
module xorshift128plus_rng_with_lehmer_seed
    import xs128p_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_cmd,
    input  logic [SEED_W-1:0]        i_seed_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [FRACTION_BITS-1:0] o_random_fraction
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    xs128p_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    xs128p_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_seed_value      (i_seed_value),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_random_fraction (o_random_fraction)
    );

endmodule

>>> tb/xorshift128plus_rng_with_lehmer_seed_tb.sv
// Testbench for the xorshift128+ generator with Lehmer seeding: a directed table, then
// random seed and next requests, each result checked against a local model of both words
// or the fixed row value. Depends on xs128p_pkg and xorshift128plus_rng_with_lehmer_seed.
module xorshift128plus_rng_with_lehmer_seed_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xs128p_pkg::*;

    localparam logic [63:0] PM_MUL     = 64'd48271;
    localparam logic [63:0] PM_MOD     = 64'd2147483647;
    localparam int          RAND_COUNT = 1900;
    localparam int          DRAIN_AT   = 950;

    typedef struct {
        logic                     cmd;
        logic [SEED_W-1:0]        seed;
        bit                       fixed;
        logic [FRACTION_BITS-1:0] want;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_cmd;
    logic [SEED_W-1:0]        i_seed_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [FRACTION_BITS-1:0] o_random_fraction;

    bit                       req_fixed;
    logic [FRACTION_BITS-1:0] req_want;

    logic [63:0]              word_lo;
    logic [63:0]              word_hi;
    logic [FRACTION_BITS-1:0] fraction_q[$];
    int                       error_count;

    t_row steer_rows[] = '{
        '{CMD_NEXT, 32'h0000_0000, 1'b1, '0},
        '{CMD_NEXT, 32'hFFFF_FFFF, 1'b1, '0},
        '{CMD_SEED, 32'h0000_0000, 1'b0, '0},
        '{CMD_NEXT, 32'h0000_0000, 1'b1, '0},
        '{CMD_SEED, 32'h0000_0001, 1'b0, '0},
        '{CMD_NEXT, 32'h0000_0000, 1'b0, '0},
        '{CMD_NEXT, 32'h0000_0000, 1'b0, '0},
        '{CMD_SEED, 32'h7FFF_FFFF, 1'b0, '0},
        '{CMD_NEXT, 32'h0000_0000, 1'b1, '0},
        '{CMD_SEED, 32'hFFFF_FFFE, 1'b0, '0},
        '{CMD_NEXT, 32'h0000_0000, 1'b1, '0},
        '{CMD_NEXT, 32'h0000_0000, 1'b1, '0},
        '{CMD_SEED, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_NEXT, 32'h0000_0000, 1'b0, '0},
        '{CMD_SEED, 32'h8000_0000, 1'b0, '0},
        '{CMD_NEXT, 32'h0000_0000, 1'b0, '0},
        '{CMD_SEED, 32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_NEXT, 32'h0000_0000, 1'b0, '0},
        '{CMD_SEED, 32'h5555_5555, 1'b0, '0},
        '{CMD_NEXT, 32'h0000_0000, 1'b0, '0},
        '{CMD_SEED, 32'h7FFF_FFFE, 1'b0, '0},
        '{CMD_SEED, 32'h1234_5678, 1'b0, '0},
        '{CMD_NEXT, 32'h0000_0000, 1'b0, '0},
        '{CMD_NEXT, 32'h0000_0000, 1'b0, '0}
    };

    xorshift128plus_rng_with_lehmer_seed u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_seed_value      (i_seed_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_random_fraction (o_random_fraction)
    );

    function automatic logic [31:0] park_miller(logic [31:0] v);
        logic [63:0] prod;
        prod = {32'b0, v} * PM_MUL;
        return 32'(prod % PM_MOD);
    endfunction

    function automatic void load_words(logic [31:0] seed);
        logic [31:0] r0, r1, r2, r3;
        r0 = park_miller(seed);
        r1 = park_miller(r0);
        r2 = park_miller(r1);
        r3 = park_miller(r2);
        word_lo = {r1, r0};
        word_hi = {r3, r2};
    endfunction

    function automatic logic [FRACTION_BITS-1:0] advance_words();
        logic [63:0] x, y, s;
        x = word_lo;
        y = word_hi;
        word_lo = y;
        x = x ^ (x << SHIFT_A);
        x = x ^ (x >> SHIFT_B);
        x = x ^ y ^ (y >> SHIFT_C);
        word_hi = x;
        s = word_lo + word_hi;
        return s[FRACTION_BITS-1:0];
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(logic cmd, logic [SEED_W-1:0] seed, bit fixed,
                                logic [FRACTION_BITS-1:0] want, bit no_gap);
        int gap;
        gap = no_gap ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_seed_value <= seed;
        req_fixed    <= fixed;
        req_want     <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("xorshift128plus_rng_with_lehmer_seed test failed");
        $finish;
    end

    initial begin
        int          n;
        int          r;
        logic        cmd;
        logic [31:0] seed;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_cmd        <= CMD_NEXT;
        i_seed_value <= '0;
        req_fixed    <= 1'b0;
        req_want     <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steer_rows[k])
            send_request(steer_rows[k].cmd, steer_rows[k].seed, steer_rows[k].fixed,
                         steer_rows[k].want, 1'b0);

        for (n = 0; n < RAND_COUNT; n++) begin
            if (n == DRAIN_AT) begin
                // hold off until every outstanding result is back
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (fraction_q.size() != 0) @(posedge i_clk);
            end
            r    = $urandom_range(0, 99);
            cmd  = (r < 13) ? CMD_SEED : CMD_NEXT;
            seed = $urandom();
            if (cmd == CMD_SEED && $urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 2))
                    0: seed = 32'h0000_0000;
                    1: seed = 32'h7FFF_FFFF;
                    default: seed = 32'hFFFF_FFFE;
                endcase
            end
            send_request(cmd, seed, 1'b0, '0, (n >= 600 && n < 800));
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (fraction_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("xorshift128plus_rng_with_lehmer_seed test passed");
        else
            $display("xorshift128plus_rng_with_lehmer_seed test failed");
        $finish;
    end

    initial begin
        int run;
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 8);
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        word_lo     = '0;
        word_hi     = '0;
        error_count = 0;
    end

    always @(posedge i_clk) begin : scoreboard
        logic [FRACTION_BITS-1:0] next_val;
        logic [FRACTION_BITS-1:0] want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (i_cmd == CMD_SEED) begin
                    load_words(i_seed_value);
                end else begin
                    next_val = advance_words();
                    fraction_q.push_back(req_fixed ? req_want : next_val);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (fraction_q.size() == 0) begin
                    $display("%0t: random_fraction expected none got %h",
                             $time, o_random_fraction);
                    error_count++;
                end else begin
                    want = fraction_q.pop_front();
                    if (o_random_fraction !== want) begin
                        $display("%0t: random_fraction expected %h got %h",
                                 $time, want, o_random_fraction);
                        error_count++;
                    end
                end
            end
        end
    end

endmodule
